FILE: hdl/tpf_pkg.sv
// Shared types and constants for the permuting tensor buffer.
package tpf_pkg;

  // Fixed field widths of the channels.
  localparam int IDX_BITS  = 12;
  localparam int SIZE_BITS = 13;
  localparam int AXES      = 4;
  localparam int SEL_BITS  = 2;

  // Saturating element counts and strides; covers every buffer depth in range.
  localparam int CNT_BITS = 21;

  // Restoring division: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS      = 4;
  localparam int DIV_PER_AXIS   = IDX_BITS / DIV_STEPS;
  localparam int DIV_AXES       = AXES - 1;
  localparam int DIV_STAGES     = DIV_AXES * DIV_PER_AXIS;

  // Input hold-off after a register write while the geometry settles.
  localparam int COOL_BITS              = 3;
  localparam logic [COOL_BITS-1:0] COOL = 3'd6;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DIM0  = 3'd0,
    REG_DIM1  = 3'd1,
    REG_DIM2  = 3'd2,
    REG_DIM3  = 3'd3,
    REG_ORDER = 3'd4,
    REG_FLIP  = 3'd5,
    REG_NDIMS = 3'd6
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // Geometry derived from the registers, consumed by the fetch pipeline.
  typedef struct packed {
    logic                                bad;
    logic [CNT_BITS-1:0]                 count;
    logic [DIV_AXES-1:0][CNT_BITS-1:0]   dst_stride;
    logic [AXES-1:0][CNT_BITS-1:0]       src_stride;
    logic                                flip_en;
    logic [SEL_BITS-1:0]                 flip_sel;
    logic [IDX_BITS-1:0]                 flip_max;
  } tpf_geom_t;

endpackage

FILE: hdl/tpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tpf_cfg.sv
// Configuration registers and the pipelined derivation of strides and checks.
module tpf_cfg import tpf_pkg::*; #(
  parameter int BUF_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [SIZE_BITS-1:0] cfg_data,
  output tpf_geom_t            geom
);

  localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(BUF_DEPTH);
  localparam logic [CNT_BITS-1:0] SAT_C   = CNT_BITS'(BUF_DEPTH + 1);

  // Product that saturates just above the buffer depth.
  function automatic logic [CNT_BITS-1:0] sat_mul(input logic [CNT_BITS-1:0] a,
                                                  input logic [SIZE_BITS-1:0] b);
    logic [CNT_BITS+SIZE_BITS-1:0] p;
    p = a * b;
    sat_mul = (p > (CNT_BITS+SIZE_BITS)'(BUF_DEPTH)) ? SAT_C : p[CNT_BITS-1:0];
  endfunction

  logic [SIZE_BITS-1:0] dim_size_r [AXES];
  logic [7:0]           axis_order_r;
  logic [2:0]           flip_axis_r;
  logic [2:0]           num_dims_r;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        dim_size_r[i] <= SIZE_BITS'(1);
      end
      axis_order_r <= 8'd228;
      flip_axis_r  <= 3'd4;
      num_dims_r   <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DIM0:  dim_size_r[0] <= cfg_data;
        REG_DIM1:  dim_size_r[1] <= cfg_data;
        REG_DIM2:  dim_size_r[2] <= cfg_data;
        REG_DIM3:  dim_size_r[3] <= cfg_data;
        REG_ORDER: axis_order_r  <= cfg_data[7:0];
        REG_FLIP:  flip_axis_r   <= cfg_data[2:0];
        REG_NDIMS: num_dims_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Step 1: order check, padded sizes and destination sizes.
  logic                 ok1_nxt, over1_nxt, fen1_nxt;
  logic [SIZE_BITS-1:0] s1_nxt [AXES];
  logic [SIZE_BITS-1:0] d1_nxt [AXES];
  logic [SEL_BITS-1:0]  src1_nxt [AXES];
  logic                 ok1_r, over1_r, fen1_r;
  logic [SIZE_BITS-1:0] s1_r [AXES];
  logic [SIZE_BITS-1:0] d1_r [AXES];
  logic [SEL_BITS-1:0]  src1_r [AXES];
  logic [SEL_BITS-1:0]  fsel1_r;

  always_comb begin
    logic [AXES-1:0]     seen;
    logic                perm_ok;
    logic                used;
    logic [SEL_BITS-1:0] src_raw;
    seen    = '0;
    perm_ok = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      used    = 3'(i) < num_dims_r;
      src_raw = axis_order_r[SEL_BITS*i +: SEL_BITS];
      if (used) begin
        if ({1'b0, src_raw} >= num_dims_r || seen[src_raw]) begin
          perm_ok = 1'b0;
        end
        seen[src_raw] = 1'b1;
      end
      src1_nxt[i] = used ? src_raw : SEL_BITS'(i);
      s1_nxt[i]   = used ? dim_size_r[i] : SIZE_BITS'(1);
    end
    for (int i = 0; i < AXES; i++) begin
      d1_nxt[i] = s1_nxt[src1_nxt[i]];
    end
    ok1_nxt   = perm_ok && (num_dims_r != 3'd0) && (num_dims_r <= 3'(AXES));
    over1_nxt = CNT_BITS'(s1_nxt[0]) > DEPTH_C;
    fen1_nxt  = flip_axis_r < num_dims_r;
  end

  always_ff @(posedge clk) begin
    ok1_r   <= ok1_nxt;
    over1_r <= over1_nxt;
    fen1_r  <= fen1_nxt;
    fsel1_r <= flip_axis_r[SEL_BITS-1:0];
    s1_r    <= s1_nxt;
    d1_r    <= d1_nxt;
    src1_r  <= src1_nxt;
  end

  // Step 2: first pairwise products.
  logic                 ok2_r, over2_r, fen2_r;
  logic [SEL_BITS-1:0]  fsel2_r;
  logic [SIZE_BITS-1:0] s2_r [AXES];
  logic [SIZE_BITS-1:0] d2_r [AXES];
  logic [SEL_BITS-1:0]  src2_r [AXES];
  logic [CNT_BITS-1:0]  p01_r, d23_r, s23_r;

  always_ff @(posedge clk) begin
    ok2_r   <= ok1_r;
    over2_r <= over1_r;
    fen2_r  <= fen1_r;
    fsel2_r <= fsel1_r;
    s2_r    <= s1_r;
    d2_r    <= d1_r;
    src2_r  <= src1_r;
    p01_r   <= sat_mul(CNT_BITS'(s1_r[0]), s1_r[1]);
    d23_r   <= sat_mul(CNT_BITS'(d1_r[2]), d1_r[3]);
    s23_r   <= sat_mul(CNT_BITS'(s1_r[2]), s1_r[3]);
  end

  // Step 3: strides and the flip span.
  logic                                ok3_r, over3_r, fen3_r;
  logic [SEL_BITS-1:0]                 fsel3_r;
  logic [SIZE_BITS-1:0]                s3_last_r;
  logic [SEL_BITS-1:0]                 src3_r [AXES];
  logic [CNT_BITS-1:0]                 p012_r;
  logic [DIV_AXES-1:0][CNT_BITS-1:0]   dstr3_r;
  logic [CNT_BITS-1:0]                 sstr3_r [AXES];
  logic [IDX_BITS-1:0]                 fmax3_r;
  logic [SIZE_BITS-1:0]                fspan;

  assign fspan = d2_r[fsel2_r] - SIZE_BITS'(1);

  always_ff @(posedge clk) begin
    ok3_r      <= ok2_r;
    over3_r    <= over2_r || (p01_r > DEPTH_C);
    fen3_r     <= fen2_r;
    fsel3_r    <= fsel2_r;
    s3_last_r  <= s2_r[AXES-1];
    src3_r     <= src2_r;
    p012_r     <= sat_mul(p01_r, s2_r[2]);
    dstr3_r[2] <= CNT_BITS'(d2_r[3]);
    dstr3_r[1] <= d23_r;
    dstr3_r[0] <= sat_mul(d23_r, d2_r[1]);
    sstr3_r[3] <= CNT_BITS'(1);
    sstr3_r[2] <= CNT_BITS'(s2_r[3]);
    sstr3_r[1] <= s23_r;
    sstr3_r[0] <= sat_mul(s23_r, s2_r[1]);
    fmax3_r    <= fspan[IDX_BITS-1:0];
  end

  // Step 4: element count, final verdict and strides per destination axis.
  tpf_geom_t           geom_r;
  logic [CNT_BITS-1:0] count4;

  assign count4 = sat_mul(p012_r, s3_last_r);

  always_ff @(posedge clk) begin
    geom_r.bad        <= !ok3_r || over3_r || (p012_r > DEPTH_C) || (count4 > DEPTH_C);
    geom_r.count      <= count4;
    geom_r.dst_stride <= dstr3_r;
    for (int i = 0; i < AXES; i++) begin
      geom_r.src_stride[i] <= sstr3_r[src3_r[i]];
    end
    geom_r.flip_en    <= fen3_r;
    geom_r.flip_sel   <= fsel3_r;
    geom_r.flip_max   <= fmax3_r;
  end

  assign geom = geom_r;

endmodule

FILE: hdl/tensor_permute_flip.sv
// Top level: tensor buffer with permuted and optionally mirrored fetches.
//
//  channel | direction | contents
//  in_     | slave     | tuser: req_type; tdata: elem_index, word_in
//  out_    | master    | tdata: word_out, status (one transaction per fetch)
//  cfg_    | write     | index 0..6 selects the register, data up to 13 bits
//
// One transaction is accepted per cycle while in_tready is high; a fetch result
// passes the nine division stages that split the index, then stages A to C.
// The whole pipeline advances together and holds while a result waits.
// After reset and after every register write the input is held off
// while the strides and checks are recomputed.
module tensor_permute_flip import tpf_pkg::*; #(
  parameter int BUF_DEPTH = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((IDX_BITS+WORD_BITS+7)/8)*8-1:0]    in_tdata,  // elem_index, word_in
  input  logic                                       in_tuser,  // req_type
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((WORD_BITS+2+7)/8)*8-1:0]           out_tdata, // word_out, status
  input  logic                                       cfg_we,
  input  logic [2:0]                                 cfg_addr,
  input  logic [SIZE_BITS-1:0]                       cfg_data
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int OUT_W = ((WORD_BITS + 2 + 7) / 8) * 8;

  typedef struct packed {
    logic                          fetch;
    logic                          ld_ok;
    status_t                       status;
    logic [WORD_BITS-1:0]          word;
    logic [IDX_BITS-1:0]           pos;
    logic [IDX_BITS-1:0]           dvd;
    logic [IDX_BITS-1:0]           part;
    logic [IDX_BITS-1:0]           quo;
    logic [AXES-1:0][IDX_BITS-1:0] coord;
  } stage_t;

  tpf_geom_t geom;

  tpf_cfg #(.BUF_DEPTH(BUF_DEPTH)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .geom     (geom)
  );

  // Global advance: everything moves unless a result is waiting.
  logic                 en;
  logic                 vc_r, fetchc_r;
  status_t              statusc_r;
  logic [COOL_BITS-1:0] cool_r;

  assign en        = !(vc_r && fetchc_r) || out_tready;
  assign in_tready = en && (cool_r == '0);

  // Hold-off counter after reset and register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r <= COOL;
    end else if (cfg_we) begin
      cool_r <= COOL;
    end else if (cool_r != '0) begin
      cool_r <= cool_r - COOL_BITS'(1);
    end
  end

  // Input register.
  logic                 v0_r, fetch0_r;
  logic [IDX_BITS-1:0]  pos0_r;
  logic [WORD_BITS-1:0] word0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fetch0_r <= in_tuser;
      pos0_r   <= in_tdata[IDX_BITS-1:0];
      word0_r  <= in_tdata[IDX_BITS +: WORD_BITS];
    end
  end

  // Division pipeline: stage 0 holds the checked item, then the index is
  // divided by each destination stride, four quotient bits a stage.
  logic [DIV_STAGES:0] dv_r;
  stage_t              ds_r   [DIV_STAGES+1];
  stage_t              ds_nxt [DIV_STAGES+1];

  always_comb begin
    ds_nxt[0]        = '0;
    ds_nxt[0].fetch  = fetch0_r;
    ds_nxt[0].ld_ok  = CNT_BITS'(pos0_r) < CNT_BITS'(BUF_DEPTH);
    ds_nxt[0].status = geom.bad ? ST_BAD :
                       (CNT_BITS'(pos0_r) >= geom.count) ? ST_RANGE : ST_OK;
    ds_nxt[0].word   = word0_r;
    ds_nxt[0].pos    = pos0_r;
    ds_nxt[0].dvd    = pos0_r;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int AX = s / DIV_PER_AXIS;
    localparam int PH = s % DIV_PER_AXIS;

    always_comb begin
      stage_t              t;
      logic [IDX_BITS:0]   trial;
      logic [CNT_BITS-1:0] diff;
      t = ds_r[s];
      for (int b = 0; b < DIV_STEPS; b++) begin
        trial = {t.part, t.dvd[IDX_BITS-1-PH*DIV_STEPS-b]};
        diff  = CNT_BITS'(trial) - geom.dst_stride[AX];
        if (CNT_BITS'(trial) >= geom.dst_stride[AX]) begin
          t.part = diff[IDX_BITS-1:0];
          t.quo[IDX_BITS-1-PH*DIV_STEPS-b] = 1'b1;
        end else begin
          t.part = trial[IDX_BITS-1:0];
        end
      end
      if (PH == DIV_PER_AXIS - 1) begin
        t.coord[AX] = t.quo;
        if (AX == DIV_AXES - 1) begin
          t.coord[AXES-1] = t.part;
        end
        t.dvd  = t.part;
        t.part = '0;
        t.quo  = '0;
      end
      ds_nxt[s+1] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DIV_STAGES-1:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r <= ds_nxt;
    end
  end

  // Stage A: mirror the flip axis and weight each coordinate by its stride.
  logic                 va_r, fetcha_r, ld_oka_r;
  status_t              statusa_r;
  logic [WORD_BITS-1:0] worda_r;
  logic [IDX_BITS-1:0]  posa_r;
  logic [AW-1:0]        contrib_nxt [AXES];
  logic [AW-1:0]        contrib_r   [AXES];

  always_comb begin
    logic [IDX_BITS-1:0]          c;
    logic [IDX_BITS+CNT_BITS-1:0] prod;
    for (int i = 0; i < AXES; i++) begin
      c = ds_r[DIV_STAGES].coord[i];
      if (geom.flip_en && geom.flip_sel == SEL_BITS'(i)) begin
        c = geom.flip_max - c;
      end
      prod           = c * geom.src_stride[i];
      contrib_nxt[i] = prod[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= dv_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fetcha_r  <= ds_r[DIV_STAGES].fetch;
      ld_oka_r  <= ds_r[DIV_STAGES].ld_ok;
      statusa_r <= ds_r[DIV_STAGES].status;
      worda_r   <= ds_r[DIV_STAGES].word;
      posa_r    <= ds_r[DIV_STAGES].pos;
      contrib_r <= contrib_nxt;
    end
  end

  // Stage B: source address, or the load address for loads.
  logic                 vb_r, fetchb_r, ld_okb_r;
  status_t              statusb_r;
  logic [WORD_BITS-1:0] wordb_r;
  logic [AW-1:0]        addrb_r;
  logic [AW-1:0]        addr_sum;

  assign addr_sum = contrib_r[0] + contrib_r[1] + contrib_r[2] + contrib_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fetchb_r  <= fetcha_r;
      ld_okb_r  <= ld_oka_r;
      statusb_r <= statusa_r;
      wordb_r   <= worda_r;
      addrb_r   <= fetcha_r ? addr_sum : AW'(posa_r);
    end
  end

  // Stage C: buffer access; loads and fetches hit it in arrival order.
  logic [WORD_BITS-1:0] rdata;

  tpf_ram #(.WIDTH(WORD_BITS), .DEPTH(BUF_DEPTH)) u_buf (
    .clk   (clk),
    .we    (en && vb_r && !fetchb_r && ld_okb_r),
    .waddr (addrb_r),
    .wdata (wordb_r),
    .re    (en),
    .raddr (addrb_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fetchc_r  <= fetchb_r;
      statusc_r <= statusb_r;
    end
  end

  // Result transaction; the word is forced to zero on any error.
  logic [WORD_BITS-1:0] word_out;

  assign word_out   = (statusc_r == ST_OK) ? rdata : '0;
  assign out_tvalid = vc_r && fetchc_r;
  assign out_tdata  = OUT_W'({statusc_r, word_out});

endmodule

FILE: hdl/tpf_chk.sv
// Port-level checker for the permuting tensor buffer, bound to the top level.
module tpf_chk #(
  parameter int WORD_BITS = 32
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((WORD_BITS+2+7)/8)*8-1:0]     out_tdata,
  input logic                                 cfg_we
);

  // A waiting result transaction holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[WORD_BITS+1:WORD_BITS] != 2'd3)
    else $error("unused status code");

  // An error result carries a zero word.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[WORD_BITS+1:WORD_BITS] != 2'd0
      |-> out_tdata[WORD_BITS-1:0] == '0)
    else $error("error result with nonzero word");

  // The input is held off right after a register write.
  a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input accepted while geometry settles");

endmodule

bind tensor_permute_flip tpf_chk #(.WORD_BITS(WORD_BITS)) u_chk (.*);

FILE: verif/tensor_permute_flip_tb.sv
// Self-checking testbench for the permuting tensor buffer: random and directed stream traffic.
module tensor_permute_flip_tb;
  import tpf_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;

  typedef struct {
    logic [31:0] word;
    status_t     st;
  } fetch_res_t;

  // Permuted-fetch predictor with its own copy of the buffer and registers.
  class permute_scoreboard;
    logic [31:0]      mem [DEPTH];
    bit               written [DEPTH];
    logic [12:0]      dim [4];
    logic [7:0]       order;
    logic [2:0]       flip;
    logic [2:0]       ndims;
    fetch_res_t       pending_q [$];
    int               mismatches;

    function new();
      for (int i = 0; i < 4; i++) dim[i] = 13'd1;
      order = 8'd228;
      flip = 3'd4;
      ndims = 3'd4;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t a, logic [12:0] v);
      case (a)
        REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: dim[a] = v;
        REG_ORDER: order = v[7:0];
        REG_FLIP:  flip = v[2:0];
        REG_NDIMS: ndims = v[2:0];
        default: ;
      endcase
    endfunction

    // Element count of the current geometry, -1 when the geometry is rejected.
    function longint elem_count();
      int n;
      logic [3:0] seen;
      longint cnt;
      n = ndims;
      seen = '0;
      if (n == 0 || n > 4) return -1;
      for (int i = 0; i < n; i++) begin
        int s;
        s = int'(order[2*i +: 2]);
        if (s >= n || seen[s]) return -1;
        seen[s] = 1'b1;
      end
      cnt = 1;
      for (int i = 0; i < n; i++) begin
        cnt = cnt * dim[i];
        if (cnt > DEPTH) return -1;
      end
      return cnt;
    endfunction

    // Source address of an in-range fetch under the current geometry.
    function longint src_addr(logic [11:0] idx);
      longint rem, addr;
      longint dsz [4], sst [4], dst [4], crd [4], scrd [4];
      int src [4];
      int n;
      n = ndims;
      for (int i = 0; i < n; i++) begin
        src[i] = int'(order[2*i +: 2]);
        dsz[i] = dim[src[i]];
      end
      sst[n-1] = 1;
      dst[n-1] = 1;
      for (int i = n - 2; i >= 0; i--) begin
        sst[i] = sst[i+1] * dim[i+1];
        dst[i] = dst[i+1] * dsz[i+1];
      end
      rem = idx;
      for (int i = 0; i < n; i++) begin
        crd[i] = rem / dst[i];
        rem = rem % dst[i];
      end
      if (flip < n) crd[flip] = dsz[flip] - 1 - crd[flip];
      for (int i = 0; i < n; i++) scrd[src[i]] = crd[i];
      addr = 0;
      for (int i = 0; i < n; i++) addr += scrd[i] * sst[i];
      return addr;
    endfunction

    // True when a fetch of idx would read an entry that was never loaded.
    function bit reads_unwritten(logic [11:0] idx);
      longint cnt, addr;
      cnt = elem_count();
      if (cnt < 0 || idx >= cnt) return 1'b0;
      addr = src_addr(idx);
      return (addr < DEPTH) && !written[addr];
    endfunction

    // Note an accepted input transaction: store a load, predict a fetch.
    function void note_input(bit is_fetch, logic [11:0] idx, logic [31:0] w);
      fetch_res_t r;
      longint cnt, addr;
      if (!is_fetch) begin
        mem[idx] = w;
        written[idx] = 1'b1;
        return;
      end
      r.word = '0;
      cnt = elem_count();
      if (cnt < 0) r.st = ST_BAD;
      else if (idx >= cnt) r.st = ST_RANGE;
      else begin
        addr = src_addr(idx);
        r.word = (addr < DEPTH) ? mem[addr] : '0;
        r.st = ST_OK;
      end
      pending_q.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [31:0] w, logic [1:0] st);
      fetch_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result word %h status %0d", w, st);
        return;
      end
      e = pending_q.pop_front();
      if (w !== e.word || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected word %h status %0d, got word %h status %0d",
                   e.word, e.st, w, st);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // elem_index [11:0], word_in [43:12]
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // word_out [31:0], status [33:32]
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [12:0] cfg_data;

  permute_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycles;

  tensor_permute_flip u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tdata[33:32]);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one input transaction, with random idle cycles ahead of it.
  task automatic send_item(bit is_fetch, logic [11:0] idx, logic [31:0] w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_fetch;
    in_tdata  <= {4'd0, w, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(is_fetch, idx, w);
  endtask

  // Send a fetch; an entry it would read that was never loaded is loaded first.
  task automatic send_fetch(logic [11:0] idx, logic [31:0] w);
    longint addr;
    if (sb.reads_unwritten(idx)) begin
      addr = sb.src_addr(idx);
      send_item(1'b0, addr[11:0], $urandom);
    end
    send_item(1'b1, idx, w);
  endtask

  // Let every predicted result arrive, then let trailing loads retire.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(cfg_reg_t a, logic [12:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(a, v);
  endtask

  task automatic set_geometry(logic [12:0] d0, logic [12:0] d1, logic [12:0] d2,
                              logic [12:0] d3, logic [7:0] ord, logic [2:0] fl,
                              logic [2:0] nd);
    write_reg(REG_DIM0, d0);
    write_reg(REG_DIM1, d1);
    write_reg(REG_DIM2, d2);
    write_reg(REG_DIM3, d3);
    write_reg(REG_ORDER, {5'd0, ord});
    write_reg(REG_FLIP, {10'd0, fl});
    write_reg(REG_NDIMS, {10'd0, nd});
    cfg_we <= 1'b0;
  endtask

  // Random geometry, mostly valid, with sizes that fit the buffer and a shuffled order.
  task automatic random_geometry();
    int nd;
    int perm [4];
    logic [7:0] ord;
    logic [12:0] d [4];
    nd = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      perm[i] = i;
      d[i] = 13'($urandom_range(1, (nd == 1) ? 4096 : (nd == 2) ? 64 : 8));
    end
    for (int i = nd - 1; i > 0; i--) begin
      int j, t;
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    ord = 8'($urandom);
    if ($urandom_range(0, 9) != 0)
      for (int i = 0; i < nd; i++) ord[2*i +: 2] = 2'(perm[i]);
    set_geometry(d[0], d[1], d[2], d[3], ord, 3'($urandom_range(0, 7)), 3'(nd));
  endtask

  // Mixed loads and fetches, fetch indexes mostly inside the tensor.
  task automatic random_items(int num);
    longint cnt;
    for (int k = 0; k < num; k++) begin
      cnt = sb.elem_count();
      if ($urandom_range(0, 3) == 0)
        send_item(1'b0, 12'($urandom_range(0, DEPTH - 1)), $urandom);
      else if (cnt > 0 && $urandom_range(0, 4) != 0)
        send_fetch(12'($urandom_range(0, cnt - 1)), $urandom);
      else
        send_fetch(12'($urandom_range(0, DEPTH - 1)), $urandom);
    end
  endtask

  initial begin
    int phases;
    sb = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_DIM0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a permuted 4-d tensor with a mirrored axis and extreme fields.
    tx_idle_pct = 31;
    rx_idle_pct = 47;
    drain();
    set_geometry(13'd4, 13'd8, 13'd2, 13'd16, 8'd99, 3'd1, 3'd4);
    send_item(1'b0, 12'd0, 32'h0000_0000);
    send_item(1'b0, 12'hFFF, 32'hFFFF_FFFF);
    send_fetch(12'd0, 32'hFFFF_FFFF);
    send_fetch(12'd1, 32'd0);
    send_fetch(12'd1023, 32'd0);
    send_fetch(12'd1024, 32'd0);
    send_fetch(12'hFFF, 32'd0);
    send_fetch(12'd517, 32'd0);

    // Directed geometries: extremes and rejected configurations.
    drain(); set_geometry(13'd4096, 13'd1, 13'd1, 13'd1, 8'd228, 3'd0, 3'd1);
    random_items(10);
    drain(); set_geometry(13'd4096, 13'd2, 13'd1, 13'd1, 8'd228, 3'd4, 3'd2);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd0, 13'd8, 13'd8, 8'd228, 3'd4, 3'd4);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd8, 13'd8, 13'd8, 8'd228, 3'd4, 3'd0);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd8, 13'd8, 13'd8, 8'd228, 3'd4, 3'd5);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd8, 13'd8, 13'd8, 8'd228, 3'd4, 3'd7);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd8, 13'd8, 13'd8, 8'h00, 3'd3, 3'd4);
    random_items(3);
    drain(); set_geometry(13'd8, 13'd4, 13'd8, 13'd8, 8'hFF, 3'd7, 3'd3);
    random_items(10);
    drain(); set_geometry(13'd16, 13'd16, 13'd16, 13'd1, 8'h06, 3'd6, 3'd3);
    random_items(10);

    // Random geometries; idling changes with each third of the run.
    phases = 14;
    for (int p = 0; p < phases; p++) begin
      drain();
      if (p < phases / 3) begin
        tx_idle_pct = 31; rx_idle_pct = 47;
      end else if (p < 2 * phases / 3) begin
        tx_idle_pct = 47; rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      random_geometry();
      random_items(32);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
